FILE: hdl/cuckoo_string_hash_table_macros.svh
// Assertion macros for the cuckoo string hash table.
// Used by the top level only; no other dependencies.
`ifndef CUCKOO_STRING_HASH_TABLE_MACROS_SVH
`define CUCKOO_STRING_HASH_TABLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CST_ASSERT_IMPLY(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("cuckoo table: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CST_ASSERT_NEXT(name, ck, rs, ante, cons) \
  name: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("cuckoo table: next-cycle check failed");

`endif

FILE: hdl/cst_pkg.sv
// Shared types and constants for the cuckoo string hash table.
// Used by every module of the block; depends on nothing.
package cst_pkg;

  localparam int SLOTS_DEF     = 256;
  localparam int KEY_LIMIT_DEF = 16;
  localparam int TABLES_DEF    = 3;

  localparam logic [31:0] DJB2_SEED = 32'd5381;
  localparam logic [31:0] FNV_BASIS = 32'h0100_0193;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
  localparam logic [31:0] CRC_SEED  = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY  = 32'hEDB8_8320;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  typedef enum logic [2:0] {
    ST_INSERTED   = 3'd0,
    ST_DUPLICATE  = 3'd1,
    ST_FOUND      = 3'd2,
    ST_NOT_FOUND  = 3'd3,
    ST_TABLE_FULL = 3'd4,
    ST_TOO_LONG   = 3'd5
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_START,
    S_P_GO,
    S_P_WAIT,
    S_P_CHECK,
    S_I_HASH0,
    S_I_HASH,
    S_I_WAIT,
    S_I_CHECK,
    S_DONE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    clr_step;
    logic    take_byte;
    logic    probe_init;
    logic    probe_next;
    logic    mod_start;
    logic    mem_read;
    logic    ins_init;
    logic    rehash_init;
    logic    rehash_step;
    logic    ins_write;
    logic    res_set;
    status_t res_code;
    logic    res_publish;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_done;
    logic too_long;
    logic mod_busy;
    logic hit;
    logic occupied;
    logic last_table;
    logic rehash_done;
    logic full;
    logic req_lookup;
    logic out_busy;
  } sts_t;

endpackage

FILE: hdl/cst_hash.sv
// Running djb2/FNV-1a/reflected CRC-32 hashes, one key byte per step cycle.
// Depends on cst_pkg for the seeds and polynomial constants.
module cst_hash import cst_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        init,
  input  logic        step,
  input  logic [7:0]  byte_in,
  output logic [31:0] djb2,
  output logic [31:0] fnv,
  output logic [31:0] crc
);

  logic [31:0] sx;
  logic [31:0] djb2_next;
  logic [31:0] fnv_next;
  logic [31:0] crc_next;

  // djb2 and FNV-1a see the byte as a signed char.
  assign sx        = {{24{byte_in[7]}}, byte_in};
  assign djb2_next = (djb2 << 5) + djb2 + sx;
  assign fnv_next  = (fnv ^ sx) * FNV_PRIME;

  always_comb begin
    crc_next = crc ^ {24'h000000, byte_in};
    for (int k = 0; k < 8; k++) begin
      crc_next = crc_next[0] ? ((crc_next >> 1) ^ CRC_POLY) : (crc_next >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || init) begin
      djb2 <= DJB2_SEED;
      fnv  <= FNV_BASIS;
      crc  <= CRC_SEED;
    end else if (step) begin
      djb2 <= djb2_next;
      fnv  <= fnv_next;
      crc  <= crc_next;
    end
  end

endmodule

FILE: hdl/cst_mod.sv
// Reduction of a 32-bit hash modulo the slot count by reciprocal multiplication.
// Depends on cst_pkg only through the common import.
module cst_mod import cst_pkg::*; #(
  parameter int SLOTS = SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [31:0]              value,
  output logic                     busy,
  output logic [$clog2(SLOTS)-1:0] slot
);

  localparam int SW = $clog2(SLOTS);
  // 2^32 / SLOTS rounded down; it fits in 32 bits since SLOTS is at least 2.
  localparam logic [31:0] RECIP    = 32'(64'h1_0000_0000 / 64'(SLOTS));
  localparam logic [31:0] SLOTS_32 = 32'(SLOTS);
  localparam logic [SW:0] SLOTS_W  = (SW + 1)'(SLOTS);

  logic [31:0] val_q;
  logic [63:0] prod;
  logic [31:0] quot_slots;
  logic [31:0] rem_full;
  logic [SW:0] rem;
  logic [1:0]  stage;

  // The quotient estimate is exact or one too small, so the first remainder
  // lies below 2 * SLOTS and a single compare and subtract finishes it.
  assign quot_slots = prod[63:32] * SLOTS_32;
  assign rem_full   = val_q - quot_slots;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      stage <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      stage <= '0;
    end else if (busy) begin
      stage <= stage + 2'd1;
      if (stage == 2'd2) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      val_q <= value;
    end else if (busy) begin
      case (stage)
        2'd0: prod <= 64'(val_q) * 64'(RECIP);
        2'd1: rem  <= rem_full[SW:0];
        2'd2: slot <= (rem >= SLOTS_W) ? SW'(rem - SLOTS_W) : rem[SW-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule

FILE: hdl/cst_dpath.sv
// Datapath: incoming key capture, hashing, slot memory, key compare,
// displacement registers and the result register. Depends on cst_pkg,
// cst_hash and cst_mod.
module cst_dpath import cst_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int KEY_LIMIT = KEY_LIMIT_DEF,
  parameter int TABLES    = TABLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output sts_t        sts,
  input  logic [7:0]  in_byte,
  input  logic [31:0] in_value,
  input  logic        in_req,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [31:0] out_value,
  output logic [1:0]  out_tab,
  output logic [7:0]  out_slot
);

  localparam int SW    = $clog2(SLOTS);
  localparam int LW    = $clog2(KEY_LIMIT + 1);
  localparam int KW    = $clog2(KEY_LIMIT);
  localparam int KB    = 8 * KEY_LIMIT;
  localparam int DEPTH = TABLES * SLOTS;
  localparam int AW    = $clog2(DEPTH);
  localparam int MW    = $clog2(SLOTS + 1);
  localparam int RW    = 1 + LW + 32 + KB;

  // Incoming key.
  logic [KEY_LIMIT-1:0][7:0] inc_key;
  logic [LW-1:0]             inc_len;
  logic                      inc_room;
  logic                      req_q;
  logic [31:0]               val_q;

  // Hashing and slot reduction.
  logic [31:0]   h_djb2, h_fnv, h_crc;
  logic [31:0]   fin;
  logic [7:0]    hash_byte;
  logic          hash_step;
  logic          hash_restart;
  logic          mod_busy;
  logic [SW-1:0] mod_slot;

  // Probe position.
  logic [1:0]    tab;
  logic [1:0]    tab_next;
  logic [AW-1:0] base;
  logic [AW-1:0] addr;
  logic [AW-1:0] idx_addr;
  logic [1:0]    idx_tab;
  logic [SW-1:0] idx_slot;

  // Slot memory and clearing pass.
  logic [RW-1:0] mem [DEPTH];
  logic [RW-1:0] rd_row;
  logic [RW-1:0] wdata;
  logic [AW-1:0] waddr;
  logic          we;
  logic [AW-1:0] clr_addr;
  logic          cleared;

  logic                      rd_occ;
  logic [LW-1:0]             rd_len;
  logic [31:0]               rd_val;
  logic [KEY_LIMIT-1:0][7:0] rd_key;
  logic                      hit;

  // Entry in flight during an insert.
  logic [KEY_LIMIT-1:0][7:0] cur_key;
  logic [LW-1:0]             cur_len;
  logic [31:0]               cur_val;
  logic                      nif;
  logic [AW-1:0]             new_addr;
  logic [1:0]                new_tab;
  logic [SW-1:0]             new_slot;
  logic [MW-1:0]             moves;
  logic [KEY_LIMIT-1:0][7:0] rh_key;
  logic [LW-1:0]             rh_cnt;

  // Pending result.
  logic [2:0]    p_status;
  logic [31:0]   p_value;
  logic [1:0]    p_tab;
  logic [SW-1:0] p_slot;
  logic [SW+7:0] p_slot_ext;

  assign inc_room = (inc_len < LW'(KEY_LIMIT));

  always_ff @(posedge clk) begin
    if (rst || cmd.res_publish) begin
      inc_len <= '0;
    end else if (cmd.take_byte && inc_room) begin
      inc_len <= inc_len + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_byte) begin
      req_q <= in_req;
      val_q <= in_value;
      if (inc_room) begin
        inc_key[inc_len[KW-1:0]] <= in_byte;
      end
    end
  end

  assign hash_restart = cmd.rehash_init || cmd.res_publish;
  assign hash_step    = (cmd.take_byte && inc_room) || cmd.rehash_step;
  assign hash_byte    = cmd.take_byte ? in_byte : rh_key[0];

  cst_hash u_hash (
    .clk     (clk),
    .rst     (rst),
    .init    (hash_restart),
    .step    (hash_step),
    .byte_in (hash_byte),
    .djb2    (h_djb2),
    .fnv     (h_fnv),
    .crc     (h_crc)
  );

  always_comb begin
    case (tab)
      2'd0:    fin = h_djb2;
      2'd1:    fin = h_fnv;
      default: fin = ~h_crc;
    endcase
  end

  cst_mod #(.SLOTS(SLOTS)) u_mod (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mod_start),
    .value (fin),
    .busy  (mod_busy),
    .slot  (mod_slot)
  );

  assign tab_next = (tab == 2'(TABLES - 1)) ? 2'd0 : tab + 2'd1;

  always_ff @(posedge clk) begin
    if (rst || cmd.probe_init || cmd.ins_init) begin
      tab <= 2'd0;
    end else if (cmd.probe_next || (cmd.ins_write && rd_occ)) begin
      tab <= tab_next;
    end
  end

  always_comb begin
    case (tab)
      2'd0:    base = '0;
      2'd1:    base = AW'(SLOTS);
      default: base = AW'(2 * SLOTS);
    endcase
  end
  assign addr = base + AW'(mod_slot);

  // Memory with separate write and read addresses: one write and one registered read a cycle.
  assign we    = cmd.clr_step || cmd.ins_write;
  assign waddr = cmd.clr_step ? clr_addr : idx_addr;
  assign wdata = cmd.clr_step ? '0 : {1'b1, cur_len, cur_val, cur_key};

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (cmd.mem_read) begin
      rd_row <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_read) begin
      idx_addr <= addr;
      idx_tab  <= tab;
      idx_slot <= mod_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      cleared  <= 1'b0;
    end else if (cmd.clr_step) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        cleared <= 1'b1;
      end
    end
  end

  assign rd_occ = rd_row[RW-1];
  assign rd_len = rd_row[RW-2 -: LW];
  assign rd_val = rd_row[KB+31:KB];
  assign rd_key = rd_row[KB-1:0];

  // Bytes past the key length are don't-care on both sides.
  always_comb begin
    hit = rd_occ && (rd_len == inc_len);
    for (int i = 0; i < KEY_LIMIT; i++) begin
      if ((LW'(i) < inc_len) && (rd_key[i] != inc_key[i])) begin
        hit = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_init) begin
      cur_key <= inc_key;
      cur_len <= inc_len;
      cur_val <= val_q;
    end else if (cmd.ins_write && rd_occ) begin
      cur_key <= rd_key;
      cur_len <= rd_len;
      cur_val <= rd_val;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nif   <= 1'b0;
      moves <= '0;
    end else if (cmd.ins_init) begin
      nif   <= 1'b1;
      moves <= '0;
    end else if (cmd.ins_write) begin
      if (rd_occ) begin
        moves <= moves + MW'(1);
      end
      if (nif) begin
        nif <= !rd_occ;
      end else if (rd_occ && (new_addr == idx_addr)) begin
        nif <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_write && nif) begin
      new_addr <= idx_addr;
      new_tab  <= idx_tab;
      new_slot <= idx_slot;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rehash_init) begin
      rh_key <= cur_key;
    end else if (cmd.rehash_step) begin
      rh_key <= {8'h00, rh_key[KEY_LIMIT-1:1]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.rehash_init) begin
      rh_cnt <= '0;
    end else if (cmd.rehash_step) begin
      rh_cnt <= rh_cnt + LW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_set) begin
      p_status <= cmd.res_code;
      p_value  <= 32'd0;
      p_tab    <= 2'd0;
      p_slot   <= '0;
      case (cmd.res_code)
        ST_FOUND: begin
          p_value <= rd_val;
          p_tab   <= idx_tab;
          p_slot  <= idx_slot;
        end
        ST_DUPLICATE: begin
          p_tab  <= idx_tab;
          p_slot <= idx_slot;
        end
        ST_INSERTED: begin
          p_tab  <= nif ? idx_tab : new_tab;
          p_slot <= nif ? idx_slot : new_slot;
        end
        default: begin
        end
      endcase
    end
  end

  assign p_slot_ext = {8'h00, p_slot};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_publish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_publish) begin
      out_status <= p_status;
      out_value  <= p_value;
      out_tab    <= p_tab;
      out_slot   <= p_slot_ext[7:0];
    end
  end

  assign sts.clr_done    = cleared;
  assign sts.too_long    = !inc_room;
  assign sts.mod_busy    = mod_busy;
  assign sts.hit         = hit;
  assign sts.occupied    = rd_occ;
  assign sts.last_table  = (tab == 2'(TABLES - 1));
  assign sts.rehash_done = (rh_cnt == cur_len);
  assign sts.full        = (moves == MW'(SLOTS));
  assign sts.req_lookup  = (req_q == REQ_LOOKUP);
  assign sts.out_busy    = out_valid;

endmodule

FILE: hdl/cst_ctrl.sv
// Controller state machine: clearing pass, byte intake, probes, displacement chain, result.
// Depends on cst_pkg for the state, command and status types.
module cst_ctrl import cst_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic in_last,
  output logic ready,
  output cmd_t cmd,
  input  sts_t sts
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR:   if (sts.clr_done) state_next = S_IDLE;
      S_IDLE:    if (in_valid && in_last) state_next = S_START;
      S_START:   state_next = sts.too_long ? S_DONE : S_P_GO;
      S_P_GO:    state_next = S_P_WAIT;
      S_P_WAIT:  if (!sts.mod_busy) state_next = S_P_CHECK;
      S_P_CHECK: begin
        if (sts.hit) begin
          state_next = S_DONE;
        end else if (!sts.last_table) begin
          state_next = S_P_GO;
        end else if (sts.req_lookup) begin
          state_next = S_DONE;
        end else begin
          state_next = S_I_HASH0;
        end
      end
      S_I_HASH0: state_next = sts.full ? S_DONE : S_I_HASH;
      S_I_HASH:  if (sts.rehash_done) state_next = S_I_WAIT;
      S_I_WAIT:  if (!sts.mod_busy) state_next = S_I_CHECK;
      S_I_CHECK: state_next = sts.occupied ? S_I_HASH0 : S_DONE;
      S_DONE:    if (!sts.out_busy) state_next = S_IDLE;
      default:   state_next = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.res_code = ST_INSERTED;
    ready        = 1'b0;
    case (state)
      S_CLEAR: cmd.clr_step = !sts.clr_done;
      S_IDLE: begin
        ready         = 1'b1;
        cmd.take_byte = in_valid;
      end
      S_START: begin
        if (sts.too_long) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_TOO_LONG;
        end else begin
          cmd.probe_init = 1'b1;
        end
      end
      S_P_GO:   cmd.mod_start = 1'b1;
      S_P_WAIT: cmd.mem_read  = !sts.mod_busy;
      S_P_CHECK: begin
        if (sts.hit) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = sts.req_lookup ? ST_FOUND : ST_DUPLICATE;
        end else if (!sts.last_table) begin
          cmd.probe_next = 1'b1;
        end else if (sts.req_lookup) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_NOT_FOUND;
        end else begin
          cmd.ins_init = 1'b1;
        end
      end
      S_I_HASH0: begin
        if (sts.full) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_TABLE_FULL;
        end else begin
          cmd.rehash_init = 1'b1;
        end
      end
      S_I_HASH: begin
        if (sts.rehash_done) begin
          cmd.mod_start = 1'b1;
        end else begin
          cmd.rehash_step = 1'b1;
        end
      end
      S_I_WAIT: cmd.mem_read = !sts.mod_busy;
      S_I_CHECK: begin
        cmd.ins_write = 1'b1;
        if (!sts.occupied) begin
          cmd.res_set  = 1'b1;
          cmd.res_code = ST_INSERTED;
        end
      end
      S_DONE:  cmd.res_publish = !sts.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

FILE: hdl/cuckoo_string_hash_table.sv
// Top level of the cuckoo string hash table: ports, controller, datapath.
// Depends on cst_pkg, cst_ctrl, cst_dpath and the assertion macro header.
//
// A string-keyed cuckoo hash table with TABLES sub-tables of SLOTS slots each.
// Key bytes arrive one request at a time on the slave stream, the final byte
// marked by tlast; tuser on that final byte selects insert (0) or lookup (1),
// and the value stored on insert rides in the upper tdata bits of that byte.
// Each final byte yields exactly one result request on the master stream.
// Table 0 is indexed by djb2, table 1 by FNV-1a with an FNV-prime seed and table 2 by reflected
// CRC-32, each reduced modulo SLOTS. Lookups probe the tables in order;
// inserts reject duplicates, place the key in table 0 and move each evicted
// resident to the next table, giving up with "table full" after SLOTS moves
// and dropping the entry then in hand. Keys of KEY_LIMIT bytes or more are
// reported as too long and leave the table untouched.
// Each table probed takes its slot index from a modulo unit that multiplies
// by the reciprocal of SLOTS, and the slot is then read from a registered
// memory. An insert that misses runs a displacement chain of placement
// attempts, the key of the entry in hand being rehashed one byte per cycle
// for each; a chain that ends in "table full" makes SLOTS such attempts.
// Publishing the result waits while the previous result is still held.
// After reset the block runs a clearing pass over all TABLES * SLOTS slots
// (768 at the defaults) of the slot memory, with tready low throughout.
`include "cuckoo_string_hash_table_macros.svh"

module cuckoo_string_hash_table import cst_pkg::*; #(
  parameter int SLOTS     = SLOTS_DEF,
  parameter int KEY_LIMIT = KEY_LIMIT_DEF,
  parameter int TABLES    = TABLES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [7:0] key_byte, [39:8] entry_value
  input  logic        s_axis_tlast,   // key_last
  input  logic        s_axis_tuser,   // req_type
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata    // [2:0] status, [34:3] found_value,
                                      // [36:35] table_index, [44:37] slot_index
);

  cmd_t        cmd;
  sts_t        sts;
  logic [2:0]  out_status;
  logic [31:0] out_value;
  logic [1:0]  out_tab;
  logic [7:0]  out_slot;

  // The controller sequences; it sees the datapath only through cmd and sts.
  cst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_last  (s_axis_tlast),
    .ready    (s_axis_tready),
    .cmd      (cmd),
    .sts      (sts)
  );

  cst_dpath #(
    .SLOTS     (SLOTS),
    .KEY_LIMIT (KEY_LIMIT),
    .TABLES    (TABLES)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .in_byte    (s_axis_tdata[7:0]),
    .in_value   (s_axis_tdata[39:8]),
    .in_req     (s_axis_tuser),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_status (out_status),
    .out_value  (out_value),
    .out_tab    (out_tab),
    .out_slot   (out_slot)
  );

  // The output register is the only buffer on the master side.
  assign m_axis_tdata = {3'b000, out_slot, out_tab, out_value, out_status};

  // No key byte may be taken before the slot memory has been cleared.
  `CST_ASSERT_IMPLY(a_ready_after_clear, clk, rst, s_axis_tready, sts.clr_done)
  // Only a lookup hit carries a stored value.
  `CST_ASSERT_IMPLY(a_value_only_found, clk, rst, m_axis_tvalid && out_status != ST_FOUND, out_value == 32'd0)
  // A new result is published only into an empty output register.
  `CST_ASSERT_IMPLY(a_publish_empty, clk, rst, cmd.res_publish, !m_axis_tvalid)
  // A taken result leaves the output empty unless a new one is published.
  `CST_ASSERT_NEXT(a_drain, clk, rst, m_axis_tvalid && m_axis_tready && !cmd.res_publish, !m_axis_tvalid)

endmodule
